/* rtl/pal_pkg.sv */
`timescale 1ns / 1ps

package pal_pkg;

    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_SEARCH = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         position;
        logic signed [31:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         found_position;
        logic signed [31:0] read_value;
        logic [7:0]         element_total;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic start;
        logic walk;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/positional_array_list_core.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_stall  o_out_item (t_out_item)
//
// one request at a time; each passes the idle, eval, walk and fin states in order; the walk
// moves the entries from the position on (insert) or after it (delete), scans all (search) or reads one (read)
// the walk is bounded by the entry count, one store read and one store write per cycle
// clear, refused requests and unused codes walk over no entries
// reset empties the list; store contents are left as they are
// a stalled result is held in the output register while the next request is taken

module positional_array_list_core #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pal_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output pal_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import pal_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    pal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    pal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request not held busy after accept");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in work");

    a_found_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.found_position != 8'd0 |->
            o_out_item.status == ST_OK)
        else $error("match position reported with error status");
`endif

endmodule

/* rtl/pal_ram.sv */
`timescale 1ns / 1ps

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pal_ctrl.sv */
`timescale 1ns / 1ps

module pal_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pal_pkg::t_dp_stat  i_stat,
    output pal_pkg::t_ctrl_cmd o_cmd,
    output logic               o_in_stall
);
    import pal_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.start  = (r_state == S_EVAL);
        o_cmd.walk   = (r_state == S_WALK);
        o_cmd.finish = (r_state == S_FIN) && i_stat.out_free;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/pal_dp.sv */
`timescale 1ns / 1ps

module pal_dp #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pal_pkg::t_ctrl_cmd i_cmd,
    output pal_pkg::t_dp_stat  o_stat,
    input  pal_pkg::t_in_item  i_in_item,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output pal_pkg::t_out_item o_out_item
);
    import pal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = ((CW > 8) ? CW : 8) + 1;

    t_in_item        r_req;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_ok;
    logic [2:0]      r_status;
    logic [CW-1:0]   r_found;
    logic [31:0]     r_rdval;
    logic            r_hit;
    logic [CW-1:0]   r_left;
    logic [AW-1:0]   r_rd_idx;
    logic            r_pend;
    logic [AW-1:0]   r_pend_idx;
    logic [CW-1:0]   r_pend_pos;
    t_out_item       r_out;
    logic            r_out_valid;

    logic [XW-1:0]   cnt_x;
    logic [XW-1:0]   pos_x;
    logic [XW-1:0]   tot_x;
    logic [XW-1:0]   fnd_x;
    logic [2:0]      ev_status;
    logic            ev_ok;
    logic [CW-1:0]   ev_left;
    logic [AW-1:0]   ev_idx;

    logic            is_ins;
    logic            is_del;
    logic            rd_issue;
    logic            fin_write;
    logic            out_free;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic [31:0]     ram_rdata;

    assign cnt_x  = XW'(r_count);
    assign pos_x  = XW'(r_req.position);
    assign is_ins = (r_req.action == ACT_INSERT);
    assign is_del = (r_req.action == ACT_DELETE);

    // range checks and walk setup
    always_comb begin
        ev_status = ST_OK;
        ev_ok     = 1'b0;
        ev_left   = '0;
        ev_idx    = '0;
        unique case (r_req.action)
            ACT_CLEAR: begin
                ev_ok = 1'b1;
            end
            ACT_INSERT: begin
                if (cnt_x >= XW'(DEPTH)) begin
                    ev_status = ST_FULL;
                end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                    ev_status = ST_BADPOS;
                end else begin
                    ev_ok   = 1'b1;
                    ev_left = CW'(cnt_x + XW'(1) - pos_x);
                    ev_idx  = AW'(cnt_x - XW'(1));
                end
            end
            ACT_DELETE: begin
                if (cnt_x == '0) begin
                    ev_status = ST_EMPTY;
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    ev_status = ST_BADPOS;
                end else begin
                    ev_ok   = 1'b1;
                    ev_left = CW'(cnt_x - pos_x);
                    ev_idx  = AW'(pos_x);
                end
            end
            ACT_SEARCH: begin
                if (cnt_x == '0) begin
                    ev_status = ST_EMPTY;
                end else begin
                    ev_status = ST_NOTFOUND;
                    ev_ok     = 1'b1;
                    ev_left   = r_count;
                end
            end
            ACT_READ: begin
                if (cnt_x == '0) begin
                    ev_status = ST_EMPTY;
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    ev_status = ST_BADPOS;
                end else begin
                    ev_ok   = 1'b1;
                    ev_left = CW'(1);
                    ev_idx  = AW'(pos_x - XW'(1));
                end
            end
            default: begin
                ev_status = ST_BADPOS;
            end
        endcase
    end

    assign rd_issue  = i_cmd.walk && (r_left != '0);
    assign fin_write = i_cmd.finish && r_ok && is_ins;
    assign ram_we    = fin_write || (i_cmd.walk && r_pend && (is_ins || is_del));
    assign ram_waddr = fin_write ? AW'(pos_x - XW'(1)) : r_pend_idx;
    assign ram_wdata = fin_write ? 32'(r_req.data_value) : ram_rdata;

    pal_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (r_req.action == ACT_CLEAR) begin
            n_count = '0;
        end else if (is_ins && r_ok) begin
            n_count = r_count + CW'(1);
        end else if (is_del && r_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign tot_x    = XW'(n_count);
    assign fnd_x    = XW'(r_found);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_left <= ev_left;
                r_pend <= 1'b0;
            end else if (i_cmd.walk) begin
                if (r_left != '0) begin
                    r_left <= r_left - CW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_item;
        end
        if (i_cmd.start) begin
            r_status <= ev_status;
            r_ok     <= ev_ok;
            r_rd_idx <= ev_idx;
            r_hit    <= 1'b0;
            r_found  <= '0;
            r_rdval  <= '0;
        end else if (i_cmd.walk) begin
            if (r_left != '0) begin
                r_rd_idx   <= is_ins ? r_rd_idx - AW'(1) : r_rd_idx + AW'(1);
                r_pend_idx <= is_ins ? r_rd_idx + AW'(1) : r_rd_idx - AW'(1);
                r_pend_pos <= CW'(r_rd_idx) + CW'(1);
            end
            if (r_pend) begin
                if (r_req.action == ACT_SEARCH) begin
                    if (!r_hit && ram_rdata == r_req.data_value) begin
                        r_hit    <= 1'b1;
                        r_status <= ST_OK;
                        r_found  <= r_pend_pos;
                    end
                end else if (r_req.action == ACT_READ) begin
                    r_rdval <= ram_rdata;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out.status         <= r_status;
            r_out.found_position <= fnd_x[7:0];
            r_out.read_value     <= r_rdval;
            r_out.element_total  <= tot_x[7:0];
        end
    end

    always_comb begin
        o_stat.walk_done = (r_left == '0) && !r_pend;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
